[rtl/asbe_pkg.sv]
package asbe_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [3:0] REQ_PUSH = 4'd0;
	localparam logic [3:0] REQ_POP = 4'd1;
	localparam logic [3:0] REQ_TOP = 4'd2;
	localparam logic [3:0] REQ_GET = 4'd3;
	localparam logic [3:0] REQ_PUT = 4'd4;
	localparam logic [3:0] REQ_SWAP = 4'd5;
	localparam logic [3:0] REQ_REMOVE_AT = 4'd6;
	localparam logic [3:0] REQ_CONTAINS = 4'd7;
	localparam logic [3:0] REQ_REMOVE_VALUE = 4'd8;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_RANGE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [3:0] req_type;
		logic [7:0] index_a;
		logic [7:0] index_b;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic found;
		logic [2:0] status;
		logic [8:0] count;
	} rsp_t;

endpackage

[rtl/asbe_ram.sv]
module asbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/asbe_front.sv]
module asbe_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input asbe_pkg::req_t req,
	output logic q_valid,
	input logic q_ready,
	output asbe_pkg::req_t q_data
);
	// two-entry queue toward the executor
	asbe_pkg::req_t buf_q [2];
	logic [1:0] fill_q;
	logic wp_q, rp_q;
	logic push, pop;

	assign req_ready = (fill_q != 2'd2);
	assign q_valid = (fill_q != 2'd0);
	assign q_data = buf_q[rp_q];
	assign push = req_valid && req_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 2'd2)
		else $error("queue fill overflow");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd2 && !pop) |=> fill_q == 2'd2)
		else $error("queue lost an entry");
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !q_ready) |=> q_valid && $stable(q_data))
		else $error("queue head changed while stalled");
endmodule

[rtl/asbe_back.sv]
module asbe_back #(
	parameter int DEPTH = 256,
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input asbe_pkg::req_t q_data,
	output logic rsp_valid,
	input logic rsp_ready,
	output asbe_pkg::rsp_t rsp
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1 = 3'd1;   // read issued for first operand
	localparam logic [2:0] S_RD2 = 3'd2;   // swap second read
	localparam logic [2:0] S_SWP = 3'd3;   // swap write-back
	localparam logic [2:0] S_SCAN = 3'd4;  // search walk
	localparam logic [2:0] S_SHFT = 3'd5;  // shift-down walk
	localparam logic [2:0] S_OUT = 3'd6;   // result waiting

	logic [2:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	asbe_pkg::req_t cur_q;
	logic [DATA_WIDTH-1:0] hold_q;
	asbe_pkg::rsp_t rsp_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	logic [DATA_WIDTH-1:0] val_in;
	logic [CW-1:0] ia, ib;

	asbe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign val_in = DATA_WIDTH'(cur_q.value);
	assign ia = CW'(q_data.index_a);
	assign ib = CW'(q_data.index_b);
	assign q_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp = rsp_q;

	// memory port steering
	always_comb begin
		we = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = DATA_WIDTH'(q_data.value);
		raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				raddr = AW'(q_data.index_a);
				if (q_data.req_type == asbe_pkg::REQ_TOP) raddr = AW'(cnt_q - 1'b1);
				// shift-down starts with the entry above the removed one
				if (q_data.req_type == asbe_pkg::REQ_REMOVE_AT) raddr = AW'(ia + 1'b1);
				if (q_valid && q_data.req_type == asbe_pkg::REQ_PUSH && cnt_q < CW'(DEPTH)) begin
					we = 1'b1;
				end
				if (q_valid && q_data.req_type == asbe_pkg::REQ_PUT && cnt_q != '0
						&& ia < cnt_q) begin
					we = 1'b1;
					waddr = AW'(q_data.index_a);
				end
			end
			S_RD1: begin
				// swap reads its second operand, a search primes entry 0
				if (cur_q.req_type == asbe_pkg::REQ_SWAP) raddr = AW'(cur_q.index_b);
			end
			S_RD2: begin
				we = 1'b1;
				waddr = AW'(cur_q.index_a);
				wdata = rdata;
			end
			S_SWP: begin
				we = 1'b1;
				waddr = AW'(cur_q.index_b);
				wdata = hold_q;
			end
			S_SCAN: raddr = AW'(ptr_q + 1'b1);
			S_SHFT: begin
				raddr = AW'(ptr_q + 2'd2);
				we = (ptr_q + 1'b1 < cnt_q);
				waddr = ptr_q[AW-1:0];
				wdata = rdata;
			end
			default: ;
		endcase
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ptr_q <= '0;
			cur_q <= '0;
			hold_q <= '0;
			rsp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					cur_q <= q_data;
					rsp_q.read_data <= '0;
					rsp_q.found <= 1'b0;
					rsp_q.status <= asbe_pkg::ST_OK;
					rsp_q.count <= 9'(cnt_q);
					ptr_q <= '0;
					state_q <= S_OUT;
					unique case (q_data.req_type)
						asbe_pkg::REQ_PUSH:
							if (cnt_q >= CW'(DEPTH)) rsp_q.status <= asbe_pkg::ST_FULL;
							else begin
								cnt_q <= cnt_q + 1'b1;
								rsp_q.count <= 9'(cnt_q + 1'b1);
							end
						asbe_pkg::REQ_POP:
							if (cnt_q == '0) rsp_q.status <= asbe_pkg::ST_EMPTY;
							else begin
								cnt_q <= cnt_q - 1'b1;
								rsp_q.count <= 9'(cnt_q - 1'b1);
							end
						asbe_pkg::REQ_TOP, asbe_pkg::REQ_GET:
							if (cnt_q == '0) rsp_q.status <= asbe_pkg::ST_EMPTY;
							else if (q_data.req_type == asbe_pkg::REQ_GET && ia >= cnt_q)
								rsp_q.status <= asbe_pkg::ST_RANGE;
							else state_q <= S_RD1;
						asbe_pkg::REQ_PUT:
							if (cnt_q == '0) rsp_q.status <= asbe_pkg::ST_EMPTY;
							else if (ia >= cnt_q) rsp_q.status <= asbe_pkg::ST_RANGE;
						asbe_pkg::REQ_SWAP:
							if (cnt_q == '0) rsp_q.status <= asbe_pkg::ST_EMPTY;
							else if (ia >= cnt_q || ib >= cnt_q)
								rsp_q.status <= asbe_pkg::ST_RANGE;
							else state_q <= S_RD1;
						asbe_pkg::REQ_REMOVE_AT:
							if (cnt_q == '0) rsp_q.status <= asbe_pkg::ST_EMPTY;
							else if (ia >= cnt_q) rsp_q.status <= asbe_pkg::ST_RANGE;
							else begin
								ptr_q <= ia;
								state_q <= S_SHFT;
							end
						asbe_pkg::REQ_CONTAINS, asbe_pkg::REQ_REMOVE_VALUE:
							if (cnt_q == '0) rsp_q.status <= asbe_pkg::ST_EMPTY;
							else state_q <= S_RD1;
						default: ;
					endcase
				end
				S_RD1: begin
					// read data for index_a or top now valid
					if (cur_q.req_type == asbe_pkg::REQ_SWAP) begin
						hold_q <= rdata;
						state_q <= S_RD2;
					end else if (cur_q.req_type == asbe_pkg::REQ_CONTAINS
							|| cur_q.req_type == asbe_pkg::REQ_REMOVE_VALUE) begin
						state_q <= S_SCAN;
					end else begin
						rsp_q.read_data <= 32'(rdata);
						state_q <= S_OUT;
					end
				end
				S_RD2: state_q <= S_SWP;
				S_SWP: state_q <= S_OUT;
				S_SCAN: begin
					// rdata is entry ptr_q
					if (rdata == val_in) begin
						rsp_q.found <= 1'b1;
						if (cur_q.req_type == asbe_pkg::REQ_REMOVE_VALUE) state_q <= S_SHFT;
						else state_q <= S_OUT;
					end else if (ptr_q + 1'b1 >= cnt_q) begin
						rsp_q.status <= asbe_pkg::ST_NOTFOUND;
						state_q <= S_OUT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_SHFT: begin
					// rdata is entry ptr+1, moved down into ptr each cycle
					if (ptr_q + 1'b1 >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
						rsp_q.count <= 9'(cnt_q - 1'b1);
						state_q <= S_OUT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_OUT: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("count above depth");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_q))
		else $error("result changed while stalled");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> $stable(cnt_q))
		else $error("count moved after result formed");
endmodule

[rtl/array_stack_bag_engine.sv]
// Get/top add a RAM read before the result; swap adds two reads and a write-back.
// Search and shift-down walk the store one entry per cycle through the single
// RAM read port.
// One request is carried out at a time; a two-entry queue lets input run ahead.
// arst_n clears the count and control; stored entries are left undefined.
module array_stack_bag_engine #(
	parameter int DEPTH = asbe_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = asbe_pkg::DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input asbe_pkg::req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output asbe_pkg::rsp_t out_data
);
	logic q_valid, q_ready;
	asbe_pkg::req_t q_data;

	asbe_front u_front (
		.clk(clk), .arst_n(arst_n), .req_valid(in_valid), .req_ready(in_ready),
		.req(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	asbe_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_data(q_data), .rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(out_data)
	);
endmodule
